### rtl/sjs_pkg.sv
// shared constants, status codes and control/status structs of the schrage job sequencer
`timescale 1ns / 1ps
package sjs_pkg;

  // field widths
  localparam int IN_W      = 16;
  localparam int TIME_W    = 23;
  localparam int JOB_NUM_W = 6;
  localparam int ORD_W     = 6;
  localparam int ST_W      = 2;

  // default store depth
  localparam int DEF_MAX_JOBS = 64;

  // per-job status codes
  localparam logic [ST_W-1:0] ST_PENDING = 2'd0;
  localparam logic [ST_W-1:0] ST_READY   = 2'd1;
  localparam logic [ST_W-1:0] ST_DONE    = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // store the request's job
    logic init;        // reset clock, makespan, sequence counters
    logic scan;        // start a pass over the store
    logic mark_ready;  // make least pending job ready
    logic jump;        // move clock to least pending release
    logic advance;     // start chosen job: clock += work
    logic retire;      // mark chosen job done, emit result
    logic clear;       // empty the store
  } sjs_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_done;   // pass finished, candidates valid
    logic lp_found;    // a pending job exists
    logic lp_due;      // its release is at or before the clock
    logic tr_found;    // a ready job exists
    logic last_job;    // the job being retired is the final one
  } sjs_stat_t;

endpackage

### rtl/sjs_ctrl.sv
// controller state machine of the schrage job sequencer
`timescale 1ns / 1ps
module sjs_ctrl
  import sjs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_final_job,
  input  sjs_stat_t stat,
  output sjs_cmd_t  cmd,
  output logic      busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_final_job) begin
            cmd.init  = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (stat.scan_done) begin
          if (stat.lp_found && stat.lp_due) begin
            cmd.mark_ready = 1'b1;
            state_nxt      = S_SCAN;
          end else if (stat.tr_found) begin
            state_nxt = S_EMIT;
          end else if (stat.lp_found) begin
            cmd.jump  = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        cmd.advance = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        cmd.retire = 1'b1;
        if (stat.last_job) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

### rtl/sjs_datapath.sv
// job store, scan comparators, clock and result registers of the schrage job sequencer
`timescale 1ns / 1ps
module sjs_datapath
  import sjs_pkg::*;
#(
  parameter int MAX_JOBS = DEF_MAX_JOBS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sjs_cmd_t             cmd,
  output sjs_stat_t            stat,
  input  logic [IN_W-1:0]      in_release_time,
  input  logic [IN_W-1:0]      in_work_time,
  input  logic [IN_W-1:0]      in_tail_time,
  output logic                 out_valid,
  output logic [JOB_NUM_W-1:0] out_job_number,
  output logic [TIME_W-1:0]    out_start_at,
  output logic [TIME_W-1:0]    out_finish_at,
  output logic                 out_last_result,
  output logic [TIME_W-1:0]    out_makespan
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  // job store memories
  logic [IN_W-1:0]  rel_mem  [MAX_JOBS];
  logic [IN_W-1:0]  work_mem [MAX_JOBS];
  logic [IN_W-1:0]  tail_mem [MAX_JOBS];
  logic [ORD_W-1:0] ord_mem  [MAX_JOBS];
  logic [ST_W-1:0]  status_r [MAX_JOBS];

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  done_cnt_r;
  logic [TIME_W-1:0] clock_r;
  logic [TIME_W-1:0] start_r;
  logic [TIME_W-1:0] best_r;
  logic [ORD_W-1:0]  seq_r;

  // scan pipeline
  logic             scan_on_r;
  logic [CNT_W-1:0] scan_addr_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [ST_W-1:0]  rd_status_r;
  logic [IN_W-1:0]  rel_q;
  logic [IN_W-1:0]  tail_q;
  logic [ORD_W-1:0] ord_q;
  logic [IN_W-1:0]  work_q;

  // candidates
  logic             lp_found_r;
  logic [IDX_W-1:0] lp_idx_r;
  logic [IN_W-1:0]  lp_rel_r;
  logic             tr_found_r;
  logic [IDX_W-1:0] tr_idx_r;
  logic [IN_W-1:0]  tr_tail_r;
  logic [ORD_W-1:0] tr_ord_r;

  // output registers
  logic                 out_valid_r;
  logic [JOB_NUM_W-1:0] out_job_number_r;
  logic [TIME_W-1:0]    out_start_at_r;
  logic [TIME_W-1:0]    out_finish_at_r;
  logic                 out_last_result_r;
  logic [TIME_W-1:0]    out_makespan_r;

  logic [IDX_W-1:0] load_idx;
  logic [IDX_W-1:0] scan_idx;
  logic             store_full;
  logic             scan_more;
  logic             scan_done;
  logic             lp_take;
  logic             tr_take;
  logic [TIME_W:0]  total;
  logic [TIME_W-1:0] best_nxt;
  logic             last_job;

  assign load_idx   = count_r[IDX_W-1:0];
  assign scan_idx   = scan_addr_r[IDX_W-1:0];
  assign store_full = (count_r >= CNT_W'(MAX_JOBS));
  assign scan_more  = (scan_addr_r < count_r);
  assign scan_done  = scan_on_r && !scan_more && !rd_vld_r;

  // release, work and tail memories: write on load, registered read
  always_ff @(posedge clk) begin
    if (cmd.load && !store_full) begin
      rel_mem[load_idx]  <= in_release_time;
      work_mem[load_idx] <= in_work_time;
      tail_mem[load_idx] <= in_tail_time;
    end
    rel_q  <= rel_mem[scan_idx];
    tail_q <= tail_mem[scan_idx];
    work_q <= work_mem[tr_idx_r];
  end

  // ready order memory: written when a job becomes ready
  always_ff @(posedge clk) begin
    if (cmd.mark_ready) begin
      ord_mem[lp_idx_r] <= seq_r;
    end
    ord_q <= ord_mem[scan_idx];
  end

  // per-job status: set pending on load, so only entries below the count matter
  always_ff @(posedge clk) begin
    if (cmd.load && !store_full) begin
      status_r[load_idx] <= ST_PENDING;
    end else if (cmd.mark_ready) begin
      status_r[lp_idx_r] <= ST_READY;
    end else if (cmd.retire) begin
      status_r[tr_idx_r] <= ST_DONE;
    end
  end

  // job count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (cmd.load && !store_full) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // scan address and read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_on_r   <= 1'b0;
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
    end else if (cmd.scan) begin
      scan_on_r   <= 1'b1;
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
    end else if (scan_on_r) begin
      rd_vld_r <= scan_more;
      if (scan_more) begin
        scan_addr_r <= scan_addr_r + CNT_W'(1);
      end
      if (scan_done) begin
        scan_on_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= scan_idx;
    rd_status_r <= status_r[scan_idx];
  end

  // candidate compare: least pending release (latest on tie),
  // largest ready tail (earliest made ready on tie)
  assign lp_take = rd_vld_r && (rd_status_r == ST_PENDING) &&
                   (!lp_found_r || (rel_q <= lp_rel_r));
  assign tr_take = rd_vld_r && (rd_status_r == ST_READY) &&
                   (!tr_found_r || (tail_q > tr_tail_r) ||
                    ((tail_q == tr_tail_r) && (ord_q < tr_ord_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_found_r <= 1'b0;
      tr_found_r <= 1'b0;
    end else if (cmd.scan) begin
      lp_found_r <= 1'b0;
      tr_found_r <= 1'b0;
    end else begin
      if (lp_take) begin
        lp_found_r <= 1'b1;
      end
      if (tr_take) begin
        tr_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lp_take) begin
      lp_idx_r <= rd_idx_r;
      lp_rel_r <= rel_q;
    end
    if (tr_take) begin
      tr_idx_r  <= rd_idx_r;
      tr_tail_r <= tail_q;
      tr_ord_r  <= ord_q;
    end
  end

  // retire math: total delivery and running makespan
  assign total    = {1'b0, clock_r} + (TIME_W + 1)'(tr_tail_r);
  assign best_nxt = (total > {1'b0, best_r}) ? total[TIME_W-1:0] : best_r;
  assign last_job = ((done_cnt_r + CNT_W'(1)) == count_r);

  // schedule clock, makespan, ready sequence and retire count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r    <= '0;
      best_r     <= '0;
      seq_r      <= '0;
      done_cnt_r <= '0;
    end else if (cmd.init || cmd.clear) begin
      clock_r    <= '0;
      best_r     <= '0;
      seq_r      <= '0;
      done_cnt_r <= '0;
    end else begin
      if (cmd.mark_ready) begin
        seq_r <= seq_r + ORD_W'(1);
      end
      if (cmd.jump) begin
        clock_r <= TIME_W'(lp_rel_r);
      end
      if (cmd.advance) begin
        clock_r <= clock_r + TIME_W'(work_q);
      end
      if (cmd.retire) begin
        best_r     <= best_nxt;
        done_cnt_r <= done_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      start_r <= clock_r;
    end
  end

  // result strobe and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.retire;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.retire) begin
      out_job_number_r  <= JOB_NUM_W'(tr_idx_r);
      out_start_at_r    <= start_r;
      out_finish_at_r   <= clock_r;
      out_last_result_r <= last_job;
      out_makespan_r    <= last_job ? best_nxt : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_job_number  = out_job_number_r;
  assign out_start_at    = out_start_at_r;
  assign out_finish_at   = out_finish_at_r;
  assign out_last_result = out_last_result_r;
  assign out_makespan    = out_makespan_r;

  assign stat.scan_done = scan_done;
  assign stat.lp_found  = lp_found_r;
  assign stat.lp_due    = ({{(TIME_W - IN_W){1'b0}}, lp_rel_r} <= clock_r);
  assign stat.tr_found  = tr_found_r;
  assign stat.last_job  = last_job;

endmodule

### rtl/schrage_job_sequencer.sv
// top level of the schrage job sequencer: controller plus datapath
//
// Single-machine non-preemptive Schrage scheduler. Each request on start
// (taken when start is high and busy is low) loads one job: release, work
// and tail time. Loads can follow back to back; jobs beyond MAX_JOBS are
// dropped. A request with in_final_job set closes the set, raises busy and
// starts scheduling.
// Each scheduling decision is one pass over the stored jobs. A scheduled
// job costs one pass per job made ready or clock jump before it plus one
// selecting pass and the emit and output states.
// Results come one per scheduled job, in schedule order, each shown for one
// cycle under out_valid; the receiver cannot stall and must take them.
// out_last_result and out_makespan mark the final result; busy then drops
// and the store is empty for the next set.
// Reset (synchronous, rst_n low) empties the store and returns to idle;
// no clearing pass is needed.
`timescale 1ns / 1ps
module schrage_job_sequencer
  import sjs_pkg::*;
#(
  parameter int MAX_JOBS = DEF_MAX_JOBS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [IN_W-1:0]      in_release_time,
  input  logic [IN_W-1:0]      in_work_time,
  input  logic [IN_W-1:0]      in_tail_time,
  input  logic                 in_final_job,
  output logic                 out_valid,
  output logic [JOB_NUM_W-1:0] out_job_number,
  output logic [TIME_W-1:0]    out_start_at,
  output logic [TIME_W-1:0]    out_finish_at,
  output logic                 out_last_result,
  output logic [TIME_W-1:0]    out_makespan
);

  sjs_cmd_t  cmd;
  sjs_stat_t stat;

  // sequencing control
  sjs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_final_job (in_final_job),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy)
  );

  // job store and scheduling datapath
  sjs_datapath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_release_time (in_release_time),
    .in_work_time    (in_work_time),
    .in_tail_time    (in_tail_time),
    .out_valid       (out_valid),
    .out_job_number  (out_job_number),
    .out_start_at    (out_start_at),
    .out_finish_at   (out_finish_at),
    .out_last_result (out_last_result),
    .out_makespan    (out_makespan)
  );

endmodule
